### design/frt_pkg.sv
`timescale 1ns / 1ps
package frt_pkg;
   localparam int unsigned CONTEXTS_DEF = 64;
   localparam int unsigned KEY_W = 32;
   localparam int unsigned IDX_W = 32;
   localparam int unsigned LEN_W = 16;
   localparam int unsigned TIME_W = 48;
   localparam int unsigned TMO_W = 32;
   localparam int unsigned CSR_W = 48;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned STATUS_W = 4;
   localparam int unsigned EXP_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ACCEPT = 4'd0;
   localparam logic [STATUS_W-1:0] ST_COMPLETE = 4'd1;
   localparam logic [STATUS_W-1:0] ST_DUP = 4'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 4'd3;
   localparam logic [STATUS_W-1:0] ST_FULL = 4'd4;
   localparam logic [STATUS_W-1:0] ST_COUNT = 4'd5;
   localparam logic [STATUS_W-1:0] ST_ORDER = 4'd6;
   localparam logic [STATUS_W-1:0] ST_SHORT = 4'd7;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd8;

   localparam logic [LEN_W-1:0] PAYLOAD_RESET = 16'd16384;
   localparam logic [TIME_W-1:0] LIMIT_RESET = 48'hFFFF_FFFF_FFFF;
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd600000;

   typedef struct packed {
      logic [KEY_W-1:0] message_key;
      logic [IDX_W-1:0] fragment_number;
      logic [IDX_W-1:0] fragment_total;
      logic [LEN_W-1:0] fragment_length;
      logic [TIME_W-1:0] now_ms;
      logic is_file_message;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TIME_W-1:0] write_offset;
      logic write_enable;
      logic [TIME_W-1:0] complete_bytes;
      logic deliver_file;
      logic [EXP_W-1:0] expired_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] total;
      logic [IDX_W-1:0] next_index;
      logic [TIME_W-1:0] received;
      logic [TIME_W-1:0] last_seen;
   } entry_type;
endpackage

### design/frt_req_if.sv
`timescale 1ns / 1ps
interface frt_req_if;
   logic valid;
   logic ready;
   frt_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/frt_rsp_if.sv
`timescale 1ns / 1ps
interface frt_rsp_if;
   logic valid;
   logic ready;
   frt_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/fragment_reassembly_tracker.sv
`timescale 1ns / 1ps
// Each request scans every context in turn through the single table read port
// (S_SCAN, S_LAST), then rereads its slot (S_RD, S_RDW), passes the decide stage
// S_DEC and posts its response in S_OUT. req_ready is low while busy. The
// response waits in an output register until taken. The next request scans meanwhile
// and holds before its decide stage while that response is still waiting.
// Reset: synchronous, active high; clears valid bits, sequencer, output valid and CSRs.
module fragment_reassembly_tracker #(
   parameter int unsigned CONTEXTS = frt_pkg::CONTEXTS_DEF
) (
   input logic clock,
   input logic reset,
   frt_req_if.sink req,
   frt_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [frt_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [frt_pkg::CSR_W-1:0] csr_write_data
);
   import frt_pkg::*;
   localparam int unsigned AW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam int unsigned CW = $clog2(CONTEXTS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_LAST = 3'd2;
   localparam logic [2:0] S_RD = 3'd3;
   localparam logic [2:0] S_RDW = 3'd4;
   localparam logic [2:0] S_DEC = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] chk_ff;
   logic chk_v_ff;
   logic [CONTEXTS-1:0] valid_ff, valid_in;
   req_type q_ff;
   logic [LEN_W-1:0] payload_ff;
   logic [TIME_W-1:0] limit_ff;
   logic [TMO_W-1:0] timeout_ff;
   logic [EXP_W-1:0] exp_ff, exp_in;
   logic hit_ff, hit_in, fre_ff, fre_in;
   logic [AW-1:0] slot_ff, slot_in, free_ff, free_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_v_ff, rsp_v_in;

   logic [AW-1:0] rd_addr;
   entry_type rd_data, wr_data;
   logic wr_en;

   frt_table #(.CONTEXTS(CONTEXTS), .AW(AW)) u_table (
      .clock(clock), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(slot_in), .wr_data(wr_data)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_v_ff;
   assign rsp.payload = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_ff <= PAYLOAD_RESET;
         limit_ff <= LIMIT_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PAYLOAD: payload_ff <= csr_write_data[LEN_W-1:0];
            CSR_LIMIT: limit_ff <= csr_write_data[TIME_W-1:0];
            CSR_TIMEOUT: timeout_ff <= csr_write_data[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   // shared compare unit: the entry read last cycle, expiry and key match
   logic [TIME_W-1:0] age;
   logic expire, live;
   assign age = q_ff.now_ms - rd_data.last_seen;
   assign expire = chk_v_ff && valid_ff[chk_ff] && (rd_data.last_seen != '0)
      && (q_ff.now_ms > rd_data.last_seen) && (age > {16'd0, timeout_ff});
   assign live = valid_ff[chk_ff] && !expire;

   // decision stage values
   logic [IDX_W:0] idx_p1;
   logic last_frag;
   logic [TIME_W:0] end_off;
   assign idx_p1 = {1'b0, q_ff.fragment_number} + 1'b1;
   assign last_frag = idx_p1 == {1'b0, q_ff.fragment_total};
   assign end_off = {1'b0, rd_data.received} + {33'd0, q_ff.fragment_length};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff;
      exp_in = exp_ff;
      hit_in = hit_ff;
      fre_in = fre_ff;
      slot_in = slot_ff;
      free_in = free_ff;
      rsp_in = rsp_ff;
      rsp_v_in = rsp_v_ff;
      rd_addr = cnt_ff[AW-1:0];
      wr_en = 1'b0;
      wr_data = rd_data;
      if (rsp_v_ff && rsp.ready) begin
         rsp_v_in = 1'b0;
      end
      // scan: expire, look up and find a free slot, one entry per cycle
      if (state_ff == S_SCAN || state_ff == S_LAST) begin
         if (chk_v_ff) begin
            if (expire) begin
               valid_in[chk_ff] = 1'b0;
               exp_in = exp_ff + 1'b1;
            end
            if (live && rd_data.key == q_ff.message_key && !hit_ff) begin
               hit_in = 1'b1;
               slot_in = chk_ff;
            end
            if (!live && !fre_ff) begin
               fre_in = 1'b1;
               free_in = chk_ff;
            end
         end
      end
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            exp_in = '0;
            hit_in = 1'b0;
            fre_in = 1'b0;
            if (req.valid && req.ready) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CONTEXTS - 1)) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_RD;
         end
         S_RD: begin
            rd_addr = slot_ff;
            state_in = S_RDW;
         end
         S_RDW: begin
            // hold the entry read until the previous response is taken
            rd_addr = slot_ff;
            if (!rsp_v_ff || rsp.ready) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            rsp_in = '0;
            rsp_in.expired_count = exp_ff;
            state_in = S_OUT;
            if (q_ff.fragment_total == '0
                  || q_ff.fragment_number >= q_ff.fragment_total) begin
               rsp_in.status = ST_INVALID;
            end else if (!hit_ff && !fre_ff) begin
               rsp_in.status = ST_FULL;
            end else if (hit_ff && rd_data.total != q_ff.fragment_total) begin
               valid_in[slot_ff] = 1'b0;
               rsp_in.status = ST_COUNT;
            end else begin
               // fresh context starts at index 0, byte 0
               wr_data.key = q_ff.message_key;
               wr_data.total = q_ff.fragment_total;
               if (!hit_ff) begin
                  slot_in = free_ff;
                  wr_data.next_index = '0;
                  wr_data.received = '0;
                  valid_in[free_ff] = 1'b1;
               end
               wr_data.last_seen = q_ff.now_ms;
               wr_en = 1'b1;
               if (q_ff.fragment_number < wr_data.next_index) begin
                  rsp_in.status = ST_DUP;
               end else if (q_ff.fragment_number != wr_data.next_index) begin
                  valid_in[slot_in] = 1'b0;
                  rsp_in.status = ST_ORDER;
               end else if (!last_frag && q_ff.fragment_length != payload_ff) begin
                  valid_in[slot_in] = 1'b0;
                  rsp_in.status = ST_SHORT;
               end else if (wr_data.received > limit_ff
                     || {1'b0, wr_data.received} + {33'd0, q_ff.fragment_length}
                        > {1'b0, limit_ff}) begin
                  valid_in[slot_in] = 1'b0;
                  rsp_in.status = ST_OVERFLOW;
               end else begin
                  rsp_in.write_offset = wr_data.received;
                  rsp_in.write_enable = 1'b1;
                  wr_data.next_index = idx_p1[IDX_W-1:0];
                  wr_data.received = hit_ff ? end_off[TIME_W-1:0]
                     : {32'd0, q_ff.fragment_length};
                  if (last_frag) begin
                     rsp_in.status = ST_COMPLETE;
                     rsp_in.complete_bytes = wr_data.received;
                     rsp_in.deliver_file = q_ff.is_file_message;
                     valid_in[slot_in] = 1'b0;
                  end else begin
                     rsp_in.status = ST_ACCEPT;
                  end
               end
            end
         end
         S_OUT: begin
            rsp_v_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rsp_v_ff <= 1'b0;
         chk_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_v_ff <= rsp_v_in;
         chk_v_ff <= (state_ff == S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      chk_ff <= rd_addr;
      exp_ff <= exp_in;
      hit_ff <= hit_in;
      fre_ff <= fre_in;
      slot_ff <= slot_in;
      free_ff <= free_in;
      rsp_ff <= rsp_in;
      if (req.valid && req.ready) begin
         q_ff <= req.payload;
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> rsp_v_ff) else $error("response lost");
   a_dec_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC) |-> !rsp_v_ff) else $error("response overwritten");
   a_exp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_ff.expired_count <= EXP_W'(CONTEXTS))) else $error("expiry count");
   a_wen_status: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_ff.write_enable == (rsp_ff.status == ST_ACCEPT
         || rsp_ff.status == ST_COMPLETE))) else $error("write enable mismatch");
`endif
endmodule

### design/frt_table.sv
`timescale 1ns / 1ps
module frt_table #(
   parameter int unsigned CONTEXTS = frt_pkg::CONTEXTS_DEF,
   parameter int unsigned AW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1
) (
   input logic clock,
   input logic [AW-1:0] rd_addr,
   output frt_pkg::entry_type rd_data,
   input logic wr_en,
   input logic [AW-1:0] wr_addr,
   input frt_pkg::entry_type wr_data
);
   import frt_pkg::*;
   entry_type mem [CONTEXTS];
   entry_type rd_data_ff;

   // registered read, single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule
